@@ hdl/lru_binding_cache_pinned_current_defines.svh @@
// Assertion macros for the verification files of the binding cache.
// Depends on nothing; included by the checker module.
`ifndef LRU_BINDING_CACHE_PINNED_CURRENT_DEFINES_SVH
`define LRU_BINDING_CACHE_PINNED_CURRENT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LBC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("binding cache check failed");

// Next-cycle implication, disabled while reset is asserted.
`define LBC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("binding cache check failed");

`endif

@@ hdl/lbc_pkg.sv @@
// Package of the binding cache: field widths, codes, state and scan flag types.
// Depends on nothing; used by every module of the block.
`default_nettype none

package lbc_pkg;

    localparam int CAPACITY_DEF = 8;
    localparam int KEY_W        = 64;
    localparam int STATUS_W     = 3;
    localparam int SLOT_W       = 3;

    localparam logic FUNC_ACQUIRE = 1'b0;
    localparam logic FUNC_RETIRE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STAT_NONE    = 3'd0,
        STAT_HIT     = 3'd1,
        STAT_MISS    = 3'd2,
        STAT_RETIRED = 3'd3,
        STAT_IGNORED = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE
    } t_state;

    typedef struct packed {
        logic hit;
        logic nc_found;
        logic any_found;
        logic free_found;
    } t_scan_flags;

endpackage

`default_nettype wire

@@ hdl/lbc_scan.sv @@
// Scan unit of the binding cache: visits one entry per cycle and keeps the
// hit, the oldest non-current entry, the oldest entry and the lowest free slot.
// Depends on lbc_pkg.
`default_nettype none

module lbc_scan #(
    parameter  int CAPACITY = lbc_pkg::CAPACITY_DEF,
    localparam int IW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic                       i_en,
    input  wire logic                       i_valid,
    input  wire logic [IW-1:0]              i_idx,
    input  wire logic [lbc_pkg::KEY_W-1:0]  i_key,
    input  wire logic [lbc_pkg::KEY_W-1:0]  i_epoch,
    input  wire logic [lbc_pkg::KEY_W-1:0]  i_match_key,
    input  wire logic [lbc_pkg::KEY_W-1:0]  i_cur_key,
    output lbc_pkg::t_scan_flags            o_flags,
    output logic [IW-1:0]                   o_hit_idx,
    output logic [IW-1:0]                   o_nc_idx,
    output logic [lbc_pkg::KEY_W-1:0]       o_nc_key,
    output logic [IW-1:0]                   o_any_idx,
    output logic [lbc_pkg::KEY_W-1:0]       o_any_key,
    output logic [IW-1:0]                   o_free_idx
);

    localparam int KW = lbc_pkg::KEY_W;

    lbc_pkg::t_scan_flags r_flags;
    logic [IW-1:0]        r_hit_idx;
    logic [IW-1:0]        r_nc_idx;
    logic [KW-1:0]        r_nc_key;
    logic [KW-1:0]        r_nc_epoch;
    logic [IW-1:0]        r_any_idx;
    logic [KW-1:0]        r_any_key;
    logic [KW-1:0]        r_any_epoch;
    logic [IW-1:0]        r_free_idx;

    logic w_take_hit;
    logic w_take_nc;
    logic w_take_any;
    logic w_take_free;

    always_comb begin
        w_take_hit  = i_en && i_valid && !r_flags.hit && (i_key == i_match_key);
        w_take_nc   = i_en && i_valid && (i_key != i_cur_key)
                      && (!r_flags.nc_found || (i_epoch < r_nc_epoch));
        w_take_any  = i_en && i_valid && (!r_flags.any_found || (i_epoch < r_any_epoch));
        w_take_free = i_en && !i_valid && !r_flags.free_found;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_start) begin
            r_flags <= '0;
        end else begin
            if (w_take_hit) begin
                r_flags.hit <= 1'b1;
            end
            if (w_take_nc) begin
                r_flags.nc_found <= 1'b1;
            end
            if (w_take_any) begin
                r_flags.any_found <= 1'b1;
            end
            if (w_take_free) begin
                r_flags.free_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take_hit) begin
            r_hit_idx <= i_idx;
        end
        if (w_take_nc) begin
            r_nc_idx   <= i_idx;
            r_nc_key   <= i_key;
            r_nc_epoch <= i_epoch;
        end
        if (w_take_any) begin
            r_any_idx   <= i_idx;
            r_any_key   <= i_key;
            r_any_epoch <= i_epoch;
        end
        if (w_take_free) begin
            r_free_idx <= i_idx;
        end
    end

    assign o_flags    = r_flags;
    assign o_hit_idx  = r_hit_idx;
    assign o_nc_idx   = r_nc_idx;
    assign o_nc_key   = r_nc_key;
    assign o_any_idx  = r_any_idx;
    assign o_any_key  = r_any_key;
    assign o_free_idx = r_free_idx;

endmodule

`default_nettype wire

@@ hdl/lru_binding_cache_pinned_current.sv @@
// Top level of the binding cache: request sequencer, key and epoch memories,
// valid bits, current key and result register. Depends on lbc_pkg, lbc_scan.
//
//   channel   direction  handshake            payload
//   request   in         i_valid / o_stall    i_func i_frame_present i_frame_id i_image_handle
//   result    out        o_valid / i_stall    o_status o_slot o_evicted o_evicted_key
//                                             o_current_cleared
//
// A request that scans reads every entry of the key and epoch memories, one entry per
// cycle, before the result register is loaded; a retire of id zero or an acquire
// without a frame skips the scan and goes straight to the decide step.
// Reset clears the valid bits, epoch counter and current key at once.
// A held result stalls only the final step; the scan of the next request proceeds.
`default_nettype none

module lru_binding_cache_pinned_current #(
    parameter int CAPACITY = lbc_pkg::CAPACITY_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic                          i_func,
    input  wire logic                          i_frame_present,
    input  wire logic [lbc_pkg::KEY_W-1:0]     i_frame_id,
    input  wire logic [lbc_pkg::KEY_W-1:0]     i_image_handle,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [lbc_pkg::STATUS_W-1:0]       o_status,
    output logic [lbc_pkg::SLOT_W-1:0]         o_slot,
    output logic                               o_evicted,
    output logic [lbc_pkg::KEY_W-1:0]          o_evicted_key,
    output logic                               o_current_cleared
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int KW = lbc_pkg::KEY_W;
    localparam int SW = IW + lbc_pkg::SLOT_W;
    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

    lbc_pkg::t_state r_state, n_state;

    logic                 r_func;
    logic                 r_skip;
    logic [KW-1:0]        r_key;
    logic [CW-1:0]        r_cnt;
    logic                 r_rd_go;
    logic                 r_rd_valid;
    logic [IW-1:0]        r_rd_idx;
    logic [KW-1:0]        r_rd_key;
    logic [KW-1:0]        r_rd_epoch;
    logic [CAPACITY-1:0]  r_valid;
    logic [KW-1:0]        r_mem_key   [CAPACITY];
    logic [KW-1:0]        r_mem_epoch [CAPACITY];
    logic [KW-1:0]        r_epoch;
    logic [KW-1:0]        r_cur;

    logic                           r_out_valid;
    logic [lbc_pkg::STATUS_W-1:0]   r_out_status;
    logic [lbc_pkg::SLOT_W-1:0]     r_out_slot;
    logic                           r_out_evicted;
    logic [KW-1:0]                  r_out_ekey;
    logic                           r_out_cleared;

    logic w_accept;
    logic w_skip;
    logic w_issue;
    logic w_commit;
    logic [IW-1:0] w_rd_addr;

    lbc_pkg::t_scan_flags s_flags;
    logic [IW-1:0] s_hit_idx;
    logic [IW-1:0] s_nc_idx;
    logic [KW-1:0] s_nc_key;
    logic [IW-1:0] s_any_idx;
    logic [KW-1:0] s_any_key;
    logic [IW-1:0] s_free_idx;

    lbc_pkg::t_status d_status;
    logic [IW-1:0]    d_idx;
    logic [SW-1:0]    d_slot_ext;
    logic             d_evicted;
    logic [KW-1:0]    d_ekey;
    logic             d_cleared;
    logic [KW-1:0]    d_cur;
    logic [KW-1:0]    d_epoch;
    logic             d_valid_we;
    logic             d_valid_val;
    logic             d_key_we;
    logic             d_epoch_we;
    logic [IW-1:0]    d_victim_idx;
    logic [KW-1:0]    d_victim_key;

    assign w_accept  = i_valid && !o_stall;
    assign w_skip    = (i_func == lbc_pkg::FUNC_RETIRE) ? (i_frame_id == '0) : !i_frame_present;
    assign w_rd_addr = r_cnt[IW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lbc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        o_stall  = 1'b1;
        w_issue  = 1'b0;
        w_commit = 1'b0;
        unique case (r_state)
            lbc_pkg::ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    n_state = w_skip ? lbc_pkg::ST_DECIDE : lbc_pkg::ST_SCAN;
                end
            end
            lbc_pkg::ST_SCAN: begin
                w_issue = (r_cnt < CAP_CNT);
                if (!w_issue && !r_rd_go) begin
                    n_state = lbc_pkg::ST_DECIDE;
                end
            end
            lbc_pkg::ST_DECIDE: begin
                if (!r_out_valid || !i_stall) begin
                    w_commit = 1'b1;
                    n_state  = lbc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = lbc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_func <= i_func;
            r_skip <= w_skip;
            r_key  <= ((i_func == lbc_pkg::FUNC_ACQUIRE) && (i_frame_id == '0))
                      ? i_image_handle : i_frame_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_rd_go <= 1'b0;
        end else begin
            if (w_accept) begin
                r_cnt <= '0;
            end else if (w_issue) begin
                r_cnt <= r_cnt + CW'(1);
            end
            r_rd_go <= w_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_rd_valid <= r_valid[w_rd_addr];
            r_rd_idx   <= w_rd_addr;
            r_rd_key   <= r_mem_key[w_rd_addr];
            r_rd_epoch <= r_mem_epoch[w_rd_addr];
        end
        if (d_key_we) begin
            r_mem_key[d_idx] <= r_key;
        end
        if (d_epoch_we) begin
            r_mem_epoch[d_idx] <= d_epoch;
        end
    end

    lbc_scan #(
        .CAPACITY (CAPACITY)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_accept),
        .i_en        (r_rd_go),
        .i_valid     (r_rd_valid),
        .i_idx       (r_rd_idx),
        .i_key       (r_rd_key),
        .i_epoch     (r_rd_epoch),
        .i_match_key (r_key),
        .i_cur_key   (r_cur),
        .o_flags     (s_flags),
        .o_hit_idx   (s_hit_idx),
        .o_nc_idx    (s_nc_idx),
        .o_nc_key    (s_nc_key),
        .o_any_idx   (s_any_idx),
        .o_any_key   (s_any_key),
        .o_free_idx  (s_free_idx)
    );

    always_comb begin
        d_victim_idx = s_flags.nc_found ? s_nc_idx : s_any_idx;
        d_victim_key = s_flags.nc_found ? s_nc_key : s_any_key;
        d_status     = lbc_pkg::STAT_NONE;
        d_idx        = '0;
        d_evicted    = 1'b0;
        d_ekey       = '0;
        d_cleared    = 1'b0;
        d_cur        = r_cur;
        d_epoch      = r_epoch;
        d_valid_we   = 1'b0;
        d_valid_val  = 1'b0;
        d_key_we     = 1'b0;
        d_epoch_we   = 1'b0;
        if (r_func == lbc_pkg::FUNC_RETIRE) begin
            if (!r_skip && s_flags.hit) begin
                d_status    = lbc_pkg::STAT_RETIRED;
                d_idx       = s_hit_idx;
                d_valid_we  = w_commit;
                d_valid_val = 1'b0;
                if (r_cur == r_key) begin
                    d_cleared = 1'b1;
                    d_cur     = '0;
                end
            end else begin
                d_status = lbc_pkg::STAT_IGNORED;
            end
        end else if (!r_skip) begin
            d_epoch    = r_epoch + KW'(1);
            d_cur      = r_key;
            d_epoch_we = w_commit;
            if (s_flags.hit) begin
                d_status = lbc_pkg::STAT_HIT;
                d_idx    = s_hit_idx;
            end else begin
                d_status    = lbc_pkg::STAT_MISS;
                d_valid_we  = w_commit;
                d_valid_val = 1'b1;
                d_key_we    = w_commit;
                if (s_flags.free_found) begin
                    d_idx = s_free_idx;
                end else begin
                    d_idx     = d_victim_idx;
                    d_evicted = 1'b1;
                    d_ekey    = d_victim_key;
                    d_cleared = (d_victim_key == r_cur);
                end
            end
        end
        d_slot_ext = {{lbc_pkg::SLOT_W{1'b0}}, d_idx};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_epoch <= '0;
            r_cur   <= '0;
        end else if (w_commit) begin
            if (d_valid_we) begin
                r_valid[d_idx] <= d_valid_val;
            end
            r_epoch <= d_epoch;
            r_cur   <= d_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_out_status  <= d_status;
            r_out_slot    <= d_slot_ext[lbc_pkg::SLOT_W-1:0];
            r_out_evicted <= d_evicted;
            r_out_ekey    <= d_ekey;
            r_out_cleared <= d_cleared;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_status          = r_out_status;
    assign o_slot            = r_out_slot;
    assign o_evicted         = r_out_evicted;
    assign o_evicted_key     = r_out_ekey;
    assign o_current_cleared = r_out_cleared;

endmodule

`default_nettype wire

@@ hdl/lbc_checker.sv @@
// Port-level checker of the binding cache and its bind to the top level.
// Depends on lbc_pkg and lru_binding_cache_pinned_current_defines.svh.
`default_nettype none

`include "lru_binding_cache_pinned_current_defines.svh"

module lbc_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_valid,
    input wire logic                          o_stall,
    input wire logic                          o_valid,
    input wire logic                          i_stall,
    input wire logic [lbc_pkg::STATUS_W-1:0]  o_status,
    input wire logic [lbc_pkg::SLOT_W-1:0]    o_slot,
    input wire logic                          o_evicted,
    input wire logic [lbc_pkg::KEY_W-1:0]     o_evicted_key,
    input wire logic                          o_current_cleared
);

    // A result held under stall stays valid and keeps its status, slot and evicted key.
    `LBC_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_status) && $stable(o_slot) && $stable(o_evicted_key))

    // The block takes one request at a time.
    `LBC_ASSERT_NEXT(a_busy, i_clk, i_rst_n, i_valid && !o_stall, o_stall)

    // Only a miss can report an eviction.
    `LBC_ASSERT_IMP(a_evict, i_clk, i_rst_n, o_valid && o_evicted, o_status == lbc_pkg::STAT_MISS)

    // An acquire without a frame leaves every other field at zero.
    `LBC_ASSERT_IMP(a_none, i_clk, i_rst_n, o_valid && (o_status == lbc_pkg::STAT_NONE), (o_slot == '0) && !o_evicted && (o_evicted_key == '0) && !o_current_cleared)

endmodule

bind lru_binding_cache_pinned_current lbc_checker u_lbc_checker (.*);

`default_nettype wire

@@ verif/tb.sv @@
// Self-checking testbench of lru_binding_cache_pinned_current: a directed table, then random
// requests, checked against fixed table results or a bench predictor of the cache state.
// Depends on lbc_pkg and the top level of the block.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP         = lbc_pkg::CAPACITY_DEF;
    localparam int KEY_W       = lbc_pkg::KEY_W;
    localparam int STATUS_W    = lbc_pkg::STATUS_W;
    localparam int SLOT_W      = lbc_pkg::SLOT_W;
    localparam int RANDOM_REQS = 1450;
    localparam int POOL_SIZE   = 12;
    localparam int STALL_PCT   = 13;
    localparam int HOLD_CYCLES = 400;
    localparam int IDLE_LIMIT  = 4000;
    localparam int DRAIN_WAIT  = 30;
    localparam logic [KEY_W-1:0] ALL_ONES = {KEY_W{1'b1}};

    typedef struct {
        logic             func;
        logic             present;
        logic [KEY_W-1:0] id;
        logic [KEY_W-1:0] handle;
    } t_req;

    typedef struct {
        lbc_pkg::t_status  status;
        logic [SLOT_W-1:0] slot;
        logic              evicted;
        logic [KEY_W-1:0]  evicted_key;
        logic              cleared;
    } t_result;

    typedef struct {
        t_req    req;
        bit      typed;
        t_result want;
    } t_row;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    logic              i_func;
    logic              i_frame_present;
    logic [KEY_W-1:0]  i_frame_id;
    logic [KEY_W-1:0]  i_image_handle;
    logic              o_valid;
    logic              i_stall;
    logic [STATUS_W-1:0] o_status;
    logic [SLOT_W-1:0] o_slot;
    logic              o_evicted;
    logic [KEY_W-1:0]  o_evicted_key;
    logic              o_current_cleared;

    lru_binding_cache_pinned_current u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_func           (i_func),
        .i_frame_present  (i_frame_present),
        .i_frame_id       (i_frame_id),
        .i_image_handle   (i_image_handle),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_status         (o_status),
        .o_slot           (o_slot),
        .o_evicted        (o_evicted),
        .o_evicted_key    (o_evicted_key),
        .o_current_cleared(o_current_cleared)
    );

    logic              ent_valid [CAP];
    logic [KEY_W-1:0]  ent_key   [CAP];
    logic [KEY_W-1:0]  ent_epoch [CAP];
    logic [KEY_W-1:0]  epoch_ctr;
    logic [KEY_W-1:0]  cur_key;

    t_result           binding_expect_q [$];
    t_row              directed_rows [$];
    logic [KEY_W-1:0]  key_pool [POOL_SIZE];
    int                error_count;
    int                results_seen;
    int                idle_cycles;
    bit                quiet;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic int find_slot(input logic [KEY_W-1:0] key);
        for (int i = 0; i < CAP; i++) begin
            if (ent_valid[i] && ent_key[i] == key) return i;
        end
        return -1;
    endfunction

    function automatic int oldest_victim();
        int best;
        best = -1;
        for (int i = 0; i < CAP; i++) begin
            if (ent_valid[i] && ent_key[i] != cur_key &&
                (best < 0 || ent_epoch[i] < ent_epoch[best])) best = i;
        end
        if (best >= 0) return best;
        for (int i = 0; i < CAP; i++) begin
            if (ent_valid[i] && (best < 0 || ent_epoch[i] < ent_epoch[best])) best = i;
        end
        return best;
    endfunction

    task automatic predict_binding(input t_req r, output t_result res);
        logic [KEY_W-1:0] key;
        int s;
        int used;
        int v;
        begin
            res.status      = lbc_pkg::STAT_NONE;
            res.slot        = '0;
            res.evicted     = 1'b0;
            res.evicted_key = '0;
            res.cleared     = 1'b0;
            if (r.func == lbc_pkg::FUNC_RETIRE) begin
                s = (r.id != '0) ? find_slot(r.id) : -1;
                if (s < 0) begin
                    res.status = lbc_pkg::STAT_IGNORED;
                end else begin
                    res.status = lbc_pkg::STAT_RETIRED;
                    res.slot   = SLOT_W'(s);
                    if (cur_key == r.id) begin
                        cur_key     = '0;
                        res.cleared = 1'b1;
                    end
                    ent_valid[s] = 1'b0;
                end
            end else if (r.present) begin
                key = (r.id != '0) ? r.id : r.handle;
                s = find_slot(key);
                epoch_ctr = epoch_ctr + 1'b1;
                if (s >= 0) begin
                    res.status   = lbc_pkg::STAT_HIT;
                    ent_epoch[s] = epoch_ctr;
                end else begin
                    used = 0;
                    for (int i = 0; i < CAP; i++) used += ent_valid[i];
                    if (used >= CAP) begin
                        v = oldest_victim();
                        if (v >= 0) begin
                            res.evicted     = 1'b1;
                            res.evicted_key = ent_key[v];
                            if (ent_key[v] == cur_key) begin
                                cur_key     = '0;
                                res.cleared = 1'b1;
                            end
                            ent_valid[v] = 1'b0;
                        end
                    end
                    s = -1;
                    for (int i = 0; i < CAP; i++) begin
                        if (s < 0 && !ent_valid[i]) s = i;
                    end
                    if (s < 0) s = 0;
                    ent_valid[s] = 1'b1;
                    ent_key[s]   = key;
                    ent_epoch[s] = epoch_ctr;
                    res.status   = lbc_pkg::STAT_MISS;
                end
                res.slot = SLOT_W'(s);
                cur_key  = key;
            end
        end
    endtask

    task automatic add_row(input logic func, input logic present, input logic [KEY_W-1:0] id,
                           input logic [KEY_W-1:0] handle, input bit typed,
                           input lbc_pkg::t_status status, input logic [SLOT_W-1:0] slot);
        t_row row;
        begin
            row.req.func            = func;
            row.req.present         = present;
            row.req.id              = id;
            row.req.handle          = handle;
            row.typed               = typed;
            row.want.status         = status;
            row.want.slot           = slot;
            row.want.evicted        = 1'b0;
            row.want.evicted_key    = '0;
            row.want.cleared        = 1'b0;
            directed_rows.push_back(row);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [KEY_W-1:0] got,
                                   input logic [KEY_W-1:0] want);
        begin
            $display("[%0t] result %0d: %s got %h expected %h", $realtime, results_seen, what,
                     got, want);
            error_count++;
        end
    endtask

    function automatic logic [KEY_W-1:0] rand_word();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [KEY_W-1:0] rand_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
        return rand_word();
    endfunction

    function automatic t_req random_request();
        t_req r;
        int kind;
        logic [KEY_W-1:0] key;
        kind = $urandom_range(0, 99);
        r.present = 1'($urandom());
        r.id      = rand_word();
        r.handle  = rand_word();
        if (kind < 70) begin
            r.func    = lbc_pkg::FUNC_ACQUIRE;
            r.present = 1'b1;
            key = rand_key();
            if (key == '0 || $urandom_range(0, 3) == 0) begin
                r.id     = '0;
                r.handle = key;
            end else begin
                r.id = key;
            end
        end else if (kind < 78) begin
            r.func    = lbc_pkg::FUNC_ACQUIRE;
            r.present = 1'b0;
        end else begin
            r.func = lbc_pkg::FUNC_RETIRE;
            kind = $urandom_range(0, 9);
            if (kind == 0) r.id = '0;
            else if (kind > 1) r.id = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        end
        return r;
    endfunction

    task automatic send_request(input t_row row);
        t_result res;
        begin
            @(negedge i_clk);
            while (!quiet && $urandom_range(0, 99) < STALL_PCT) begin
                i_valid <= 1'b0;
                @(negedge i_clk);
            end
            i_valid         <= 1'b1;
            i_func          <= row.req.func;
            i_frame_present <= row.req.present;
            i_frame_id      <= row.req.id;
            i_image_handle  <= row.req.handle;
            @(posedge i_clk);
            while (o_stall !== 1'b0) @(posedge i_clk);
            predict_binding(row.req, res);
            binding_expect_q.push_back(row.typed ? row.want : res);
        end
    endtask

    initial begin
        t_row row;
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_func          = lbc_pkg::FUNC_ACQUIRE;
        i_frame_present = 1'b0;
        i_frame_id      = '0;
        i_image_handle  = '0;
        error_count     = 0;
        quiet           = 1'b0;
        epoch_ctr       = '0;
        cur_key         = '0;
        for (int i = 0; i < CAP; i++) begin
            ent_valid[i] = 1'b0;
            ent_key[i]   = '0;
            ent_epoch[i] = '0;
        end
        key_pool[0] = '0;
        key_pool[1] = ALL_ONES;
        key_pool[2] = 64'd1;
        key_pool[3] = 64'h8000_0000_0000_0000;
        for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = rand_word();

        add_row(lbc_pkg::FUNC_RETIRE,  1'b0, '0, '0, 1, lbc_pkg::STAT_IGNORED, 3'd0);
        add_row(lbc_pkg::FUNC_ACQUIRE, 1'b0, ALL_ONES, ALL_ONES, 1, lbc_pkg::STAT_NONE, 3'd0);
        add_row(lbc_pkg::FUNC_RETIRE,  1'b1, ALL_ONES, ALL_ONES, 1, lbc_pkg::STAT_IGNORED,
                3'd0);
        add_row(lbc_pkg::FUNC_ACQUIRE, 1'b1, ALL_ONES, '0, 1, lbc_pkg::STAT_MISS, 3'd0);
        add_row(lbc_pkg::FUNC_ACQUIRE, 1'b1, '0, '0, 1, lbc_pkg::STAT_MISS, 3'd1);
        add_row(lbc_pkg::FUNC_ACQUIRE, 1'b1, '0, 64'h8000_0000_0000_0001, 1,
                lbc_pkg::STAT_MISS, 3'd2);
        add_row(lbc_pkg::FUNC_ACQUIRE, 1'b1, ALL_ONES, 64'h1234, 1, lbc_pkg::STAT_HIT, 3'd0);
        add_row(lbc_pkg::FUNC_RETIRE,  1'b1, '0, ALL_ONES, 1, lbc_pkg::STAT_IGNORED, 3'd0);
        for (int k = 1; k <= 6; k++) begin
            add_row(lbc_pkg::FUNC_ACQUIRE, 1'b1, 64'(k), rand_word(), 0, lbc_pkg::STAT_NONE,
                    3'd0);
        end
        add_row(lbc_pkg::FUNC_ACQUIRE, 1'b1, '0,     '0, 0, lbc_pkg::STAT_NONE, 3'd0);
        add_row(lbc_pkg::FUNC_RETIRE,  1'b0, '0,     '0, 0, lbc_pkg::STAT_NONE, 3'd0);
        add_row(lbc_pkg::FUNC_RETIRE,  1'b0, 64'd6,  '0, 0, lbc_pkg::STAT_NONE, 3'd0);
        add_row(lbc_pkg::FUNC_ACQUIRE, 1'b1, 64'd7,  '0, 0, lbc_pkg::STAT_NONE, 3'd0);
        add_row(lbc_pkg::FUNC_RETIRE,  1'b1, 64'd7,  ALL_ONES, 0, lbc_pkg::STAT_NONE, 3'd0);
        add_row(lbc_pkg::FUNC_ACQUIRE, 1'b1, 64'd8,  '0, 0, lbc_pkg::STAT_NONE, 3'd0);
        add_row(lbc_pkg::FUNC_ACQUIRE, 1'b1, 64'd9,  '0, 0, lbc_pkg::STAT_NONE, 3'd0);
        add_row(lbc_pkg::FUNC_ACQUIRE, 1'b1, 64'd10, '0, 0, lbc_pkg::STAT_NONE, 3'd0);
        add_row(lbc_pkg::FUNC_RETIRE,  1'b1, 64'hdead_beef_0000_0001, ALL_ONES, 1,
                lbc_pkg::STAT_IGNORED, 3'd0);
        add_row(lbc_pkg::FUNC_ACQUIRE, 1'b0, 64'd3,  '0, 1, lbc_pkg::STAT_NONE, 3'd0);

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_rows[i]) send_request(directed_rows[i]);

        row.typed = 0;
        for (int n = 0; n < RANDOM_REQS; n++) begin
            quiet = (n >= 900 && n < 1150);
            if (n == 700) begin
                @(negedge i_clk);
                i_valid <= 1'b0;
                while (binding_expect_q.size() != 0) @(posedge i_clk);
            end
            row.req = random_request();
            send_request(row);
        end
        quiet = 1'b0;
        @(negedge i_clk);
        i_valid <= 1'b0;

        while (binding_expect_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 0;
        i_stall   = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (!hold_done && results_seen >= 300) begin
                hold_done = 1;
                hold_left = HOLD_CYCLES - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= !quiet && ($urandom_range(0, 99) < STALL_PCT);
            end
        end
    end

    initial results_seen = 0;

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (binding_expect_q.size() == 0) begin
                report_mismatch("unexpected result, status", 64'(o_status), '0);
            end else begin
                want = binding_expect_q.pop_front();
                if (o_status !== want.status)
                    report_mismatch("status", 64'(o_status), 64'(want.status));
                if (o_slot !== want.slot)
                    report_mismatch("slot", 64'(o_slot), 64'(want.slot));
                if (o_evicted !== want.evicted)
                    report_mismatch("evicted", 64'(o_evicted), 64'(want.evicted));
                if (o_evicted_key !== want.evicted_key)
                    report_mismatch("evicted_key", o_evicted_key, want.evicted_key);
                if (o_current_cleared !== want.cleared)
                    report_mismatch("current_cleared", 64'(o_current_cleared),
                                    64'(want.cleared));
            end
            results_seen++;
        end
    end

    initial idle_cycles = 0;

    always @(posedge i_clk) begin
        if ((i_valid === 1'b1 && o_stall === 1'b0) || (o_valid === 1'b1 && i_stall === 1'b0)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("[%0t] no request or result moved for %0d cycles", $realtime,
                         IDLE_LIMIT);
                $display("Some tests failed");
                $finish;
            end
        end
    end

endmodule

`default_nettype wire
